[rtl/btff_pkg.sv]
// Package for the boundary-tag first-fit allocator: sizes, codes, tag and queue types.
// No dependencies.
package btff_pkg;

    localparam int unsigned POOL_BYTES  = 65536;
    localparam int unsigned ALIGN_BYTES = 8;
    localparam int unsigned TAG_BYTES   = 16;

    localparam int unsigned TAG_SPAN  = ((TAG_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
    localparam int unsigned OVERHEAD  = 2 * TAG_SPAN;
    localparam int unsigned MIN_SPAN  = OVERHEAD + ALIGN_BYTES;
    localparam int unsigned POOL_USE  = (POOL_BYTES / ALIGN_BYTES) * ALIGN_BYTES;
    localparam int unsigned DEPTH     = POOL_BYTES / ALIGN_BYTES;

    localparam int unsigned AW = $clog2(POOL_BYTES) + 2;   // byte address / size width
    localparam int unsigned IW = $clog2(DEPTH);            // tag store index width
    localparam int unsigned TW = AW + 1;                   // tag word: size + free flag

    typedef logic [AW-1:0] addr_t;
    typedef logic [IW-1:0] idx_t;

    typedef enum logic [1:0] {
        CMD_ALLOC   = 2'd0,
        CMD_FREE    = 2'd1,
        CMD_REALLOC = 2'd2,
        CMD_RESET   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NOP     = 2'd1,
        ST_NOSPACE = 2'd2,
        ST_INVALID = 2'd3
    } status_t;

    // classified request passed from the front part to the back part
    typedef struct packed {
        cmd_t        cmd;
        logic        present;
        logic        zero_req;
        logic [15:0] req;
        logic [15:0] pay;
        addr_t       needed;
    } op_t;

    function automatic idx_t slot(input addr_t a);
        return idx_t'(a / ALIGN_BYTES);
    endfunction

endpackage

[rtl/btff_if.sv]
// Valid/ready word channel used by the allocator's request and response ports.
// No dependencies.
interface btff_if #(parameter int unsigned W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/boundary_tag_first_fit_allocator.sv]
// Top level of the boundary-tag first-fit allocator.
// Depends on btff_pkg, btff_if, btff_front and btff_back.
//
// Each request word (alloc, free, realloc, pool reset) returns one response word. The front
// part accepts and classifies requests into a two-word queue; the back part walks the block
// tags in a 64K-byte pool held in an 8192 x 19 tag RAM, one RAM access per cycle. A request
// leaves the queue, then the first-fit or address walk reads and examines each block header,
// followed by tag reads, rewrites and merging (more of them for a realloc that moves); the
// last state presents the response word until it is taken. After power-on reset and after
// a pool reset command the tag RAM is cleared and the pool tags are written before new
// requests are served.
module boundary_tag_first_fit_allocator (
    input logic clk,
    input logic rst_n,
    btff_if.sink   req,
    btff_if.source rsp
);
    import btff_pkg::*;

    logic  q_valid, q_ready;
    op_t   q_op;
    logic [1:0]  st;
    logic [15:0] ra, cl;
    logic        mv;

    // request word: {command, request_size, address_present, payload_address}
    btff_front u_front (
        .clk(clk), .rst_n(rst_n),
        .req_valid(req.valid), .req_ready(req.ready),
        .command(req.data[34:33]), .request_size(req.data[32:17]),
        .address_present(req.data[16]), .payload_address(req.data[15:0]),
        .q_valid(q_valid), .q_ready(q_ready), .q_op(q_op)
    );

    btff_back u_back (
        .clk(clk), .rst_n(rst_n),
        .q_valid(q_valid), .q_ready(q_ready), .q_op(q_op),
        .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
        .status(st), .result_address(ra), .moved(mv), .copy_length(cl)
    );

    // response word: {status, result_address, moved, copy_length}
    assign rsp.data = {st, ra, mv, cl};
endmodule

[rtl/btff_ram.sv]
// Generic single-port RAM with registered read.
// No dependencies.
module btff_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule

[rtl/btff_front.sv]
// Front part: accepts a request word, classifies it and computes the needed block size.
// Depends on btff_pkg.
module btff_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            req_valid,
    output logic            req_ready,
    input  logic [1:0]      command,
    input  logic [15:0]     request_size,
    input  logic            address_present,
    input  logic [15:0]     payload_address,
    output logic            q_valid,
    input  logic            q_ready,
    output btff_pkg::op_t   q_op
);
    import btff_pkg::*;

    // two-entry queue
    op_t         buf_reg [2];
    logic        wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0]  cnt_reg, cnt_next;
    op_t         op;
    logic [AW-1:0] rnd;
    logic        push, pop;

    always_comb
    begin
        rnd = (AW'(request_size) + AW'(ALIGN_BYTES - 1)) & ~AW'(ALIGN_BYTES - 1);
        op.cmd      = cmd_t'(command);
        op.present  = address_present;
        op.zero_req = (request_size == 16'd0);
        op.req      = request_size;
        op.pay      = payload_address;
        op.needed   = (rnd + AW'(OVERHEAD) < AW'(MIN_SPAN)) ? AW'(MIN_SPAN)
                                                         : rnd + AW'(OVERHEAD);
    end

    assign req_ready = (cnt_reg != 2'd2);
    assign q_valid   = (cnt_reg != 2'd0);
    assign q_op      = buf_reg[rp_reg];
    assign push      = req_valid && req_ready;
    assign pop       = q_valid && q_ready;

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wp_reg] <= op;
    end
endmodule

[rtl/btff_back.sv]
// Back part: walks and rewrites the boundary tags in the tag RAM, one access per cycle.
// Depends on btff_pkg and btff_ram.
module btff_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    output logic             q_ready,
    input  btff_pkg::op_t    q_op,
    output logic             rsp_valid,
    input  logic             rsp_ready,
    output logic [1:0]       status,
    output logic [15:0]      result_address,
    output logic             moved,
    output logic [15:0]      copy_length
);
    import btff_pkg::*;

    typedef enum logic [23:0] {
        S_CLEAR  = 24'h000001,  // zero the store
        S_INIT   = 24'h000002,  // write the pool header/footer
        S_IDLE   = 24'h000004,
        S_WRD    = 24'h000008,  // walk: issue header read
        S_WCHK   = 24'h000010,  // walk: examine header
        S_NRD    = 24'h000020,  // read next block header
        S_NCHK   = 24'h000040,
        S_DECIDE = 24'h000080,
        S_FREE   = 24'h000100,  // free old block then merge
        S_MPRD   = 24'h000200,  // merge: read previous footer
        S_MPCHK  = 24'h000400,
        S_MNRD   = 24'h000800,
        S_MNCHK  = 24'h001000,
        S_MWR    = 24'h002000,
        S_CARVE  = 24'h004000,  // split/mark
        S_WR     = 24'h008000,  // generic tag-write sequencer
        S_DONE   = 24'h010000,
        S_OUT    = 24'h020000
    } state_t;

    typedef enum logic [2:0] {
        PH_NONE, PH_ALLOC_FIT, PH_RE_FIT, PH_AFTER_CARVE, PH_SHRINK_MERGE,
        PH_AFTER_FREE, PH_AFTER_GROW
    } phase_t;

    state_t  st_reg;
    phase_t  ph_reg;
    op_t     op_reg;
    addr_t   a_reg, sz_reg, h_reg, hs_reg, na_reg, p_reg, tot_reg, nsz_reg;
    logic    walk_live_reg;  // walk searches live block (else first fit)
    logic    pf_reg, nf_reg;
    logic    boot_reg;       // power-on init pending: it returns no word
    idx_t    clr_reg;
    // write queue: up to four tag writes (two blocks)
    addr_t   wa_reg [4];
    logic [TW-1:0] wd_reg [4];
    logic [2:0] wn_reg, wi_reg;
    state_t  wret_reg;
    logic [1:0] ost_reg;
    logic [15:0] ores_reg, ocp_reg;
    logic    omv_reg;

    logic        we;
    idx_t        ra;
    logic [TW-1:0] wdat, rd;
    addr_t       rsz;
    logic        rfree;

    btff_ram #(.WIDTH(TW), .DEPTH(DEPTH)) u_tags (
        .clk(clk), .we(we), .addr(ra), .wdata(wdat), .rdata(rd)
    );

    assign rsz   = rd[AW:1];
    assign rfree = rd[0];

    function automatic logic sane(input addr_t a, input addr_t s);
        return (a < AW'(POOL_USE)) && (s >= AW'(MIN_SPAN)) && (s <= AW'(POOL_USE) - a);
    endfunction

    assign q_ready        = (st_reg == S_IDLE);
    assign rsp_valid      = (st_reg == S_OUT);
    assign status         = ost_reg;
    assign result_address = ores_reg;
    assign moved          = omv_reg;
    assign copy_length    = ocp_reg;

    // RAM port mux
    always_comb
    begin
        we   = 1'b0;
        ra   = slot(a_reg);
        wdat = '0;
        case (st_reg)
            S_CLEAR:
            begin
                we = 1'b1;
                ra = clr_reg;
            end
            S_WR:
            begin
                we   = 1'b1;
                ra   = slot(wa_reg[wi_reg[1:0]]);
                wdat = wd_reg[wi_reg[1:0]];
            end
            S_NRD:   ra = slot(na_reg);
            S_MPRD:  ra = slot(a_reg - AW'(TAG_SPAN));
            S_MNRD:  ra = slot(a_reg + sz_reg);
            default: ra = slot(a_reg);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_CLEAR;
            clr_reg  <= '0;
            ph_reg   <= PH_NONE;
            wn_reg   <= '0;
            wi_reg   <= '0;
            wret_reg <= S_DONE;
            boot_reg <= 1'b1;
        end
        else
        begin
            case (st_reg)
                S_CLEAR:
                begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == idx_t'(DEPTH - 1))
                        st_reg <= S_INIT;
                end
                S_INIT:
                begin
                    wa_reg[0] <= '0;
                    wd_reg[0] <= {AW'(POOL_USE), 1'b1};
                    wa_reg[1] <= AW'(POOL_USE - TAG_SPAN);
                    wd_reg[1] <= {AW'(POOL_USE), 1'b1};
                    wn_reg <= 3'd2; wi_reg <= '0;
                    // power-on init goes straight to idle without a word
                    wret_reg <= boot_reg ? S_IDLE : S_DONE;
                    boot_reg <= 1'b0;
                    st_reg <= S_WR;
                end
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        op_reg   <= q_op;
                        ost_reg  <= ST_OK;
                        ores_reg <= '0;
                        omv_reg  <= 1'b0;
                        ocp_reg  <= '0;
                        a_reg    <= '0;
                        if (q_op.cmd == CMD_RESET)
                        begin
                            clr_reg <= '0;
                            st_reg  <= S_CLEAR;
                        end
                        else if (q_op.cmd == CMD_ALLOC ||
                                 (q_op.cmd == CMD_REALLOC && !q_op.present))
                        begin
                            if (q_op.zero_req)
                            begin
                                ost_reg <= ST_NOP;
                                st_reg  <= S_OUT;
                            end
                            else
                            begin
                                walk_live_reg <= 1'b0;
                                ph_reg <= PH_ALLOC_FIT;
                                st_reg <= S_WRD;
                            end
                        end
                        else if (!q_op.present)
                        begin
                            ost_reg <= ST_NOP;
                            st_reg  <= S_OUT;
                        end
                        else
                        begin
                            walk_live_reg <= 1'b1;
                            st_reg <= S_WRD;
                        end
                    end
                end
                S_WRD: st_reg <= S_WCHK;
                S_WCHK:
                begin
                    if (!sane(a_reg, rsz))
                    begin
                        if (walk_live_reg) ost_reg <= ST_INVALID;
                        else ost_reg <= ST_NOSPACE;
                        st_reg <= S_OUT;
                    end
                    else if (walk_live_reg)
                    begin
                        if (a_reg + AW'(TAG_SPAN) == AW'(op_reg.pay))
                        begin
                            if (rfree)
                            begin
                                ost_reg <= ST_INVALID;
                                st_reg  <= S_OUT;
                            end
                            else
                            begin
                                h_reg  <= a_reg;
                                hs_reg <= rsz;
                                na_reg <= a_reg + rsz;
                                st_reg <= S_DECIDE;
                            end
                        end
                        else if (a_reg + AW'(TAG_SPAN) > AW'(op_reg.pay))
                        begin
                            ost_reg <= ST_INVALID;
                            st_reg  <= S_OUT;
                        end
                        else
                        begin
                            a_reg  <= a_reg + rsz;
                            st_reg <= S_WRD;
                        end
                    end
                    else if (rfree && rsz >= op_reg.needed)
                    begin
                        // found fit: carve
                        tot_reg <= rsz;
                        st_reg  <= S_CARVE;
                    end
                    else
                    begin
                        a_reg  <= a_reg + rsz;
                        st_reg <= S_WRD;
                    end
                end
                S_DECIDE:
                begin
                    if (op_reg.cmd == CMD_FREE || op_reg.zero_req)
                    begin
                        ost_reg <= (op_reg.cmd == CMD_FREE) ? ST_OK : ST_NOP;
                        a_reg   <= h_reg;
                        ph_reg  <= PH_AFTER_FREE;
                        st_reg  <= S_FREE;
                    end
                    else if (op_reg.needed <= hs_reg)
                    begin
                        ores_reg <= op_reg.pay;
                        if (hs_reg - op_reg.needed >= AW'(MIN_SPAN))
                        begin
                            wa_reg[0] <= h_reg;
                            wd_reg[0] <= {op_reg.needed, 1'b0};
                            wa_reg[1] <= h_reg + op_reg.needed - AW'(TAG_SPAN);
                            wd_reg[1] <= {op_reg.needed, 1'b0};
                            wa_reg[2] <= h_reg + op_reg.needed;
                            wd_reg[2] <= {hs_reg - op_reg.needed, 1'b1};
                            wa_reg[3] <= h_reg + hs_reg - AW'(TAG_SPAN);
                            wd_reg[3] <= {hs_reg - op_reg.needed, 1'b1};
                            wn_reg <= 3'd4; wi_reg <= '0;
                            a_reg  <= h_reg + op_reg.needed;
                            sz_reg <= hs_reg - op_reg.needed;
                            wret_reg <= S_MPRD;
                            st_reg <= S_WR;
                        end
                        else
                            st_reg <= S_OUT;
                    end
                    else
                        st_reg <= S_NRD;
                end
                S_NRD: st_reg <= S_NCHK;
                S_NCHK:
                begin
                    if (na_reg < AW'(POOL_USE) && sane(na_reg, rsz) && rfree &&
                        hs_reg + rsz >= op_reg.needed)
                    begin
                        ores_reg <= op_reg.pay;
                        a_reg    <= h_reg;
                        tot_reg  <= hs_reg + rsz;
                        ph_reg   <= PH_AFTER_GROW;
                        st_reg   <= S_CARVE;
                    end
                    else
                    begin
                        a_reg  <= '0;
                        walk_live_reg <= 1'b0;
                        ph_reg <= PH_RE_FIT;
                        st_reg <= S_WRD;
                    end
                end
                S_CARVE:
                begin
                    if (tot_reg - op_reg.needed >= AW'(MIN_SPAN))
                    begin
                        wa_reg[0] <= a_reg;
                        wd_reg[0] <= {op_reg.needed, 1'b0};
                        wa_reg[1] <= a_reg + op_reg.needed - AW'(TAG_SPAN);
                        wd_reg[1] <= {op_reg.needed, 1'b0};
                        wa_reg[2] <= a_reg + op_reg.needed;
                        wd_reg[2] <= {tot_reg - op_reg.needed, 1'b1};
                        wa_reg[3] <= a_reg + tot_reg - AW'(TAG_SPAN);
                        wd_reg[3] <= {tot_reg - op_reg.needed, 1'b1};
                        wn_reg <= 3'd4;
                    end
                    else
                    begin
                        wa_reg[0] <= a_reg;
                        wd_reg[0] <= {tot_reg, 1'b0};
                        wa_reg[1] <= a_reg + tot_reg - AW'(TAG_SPAN);
                        wd_reg[1] <= {tot_reg, 1'b0};
                        wn_reg <= 3'd2;
                    end
                    wi_reg <= '0;
                    if (ph_reg == PH_RE_FIT)
                    begin
                        ores_reg <= 16'(a_reg + AW'(TAG_SPAN));
                        omv_reg  <= 1'b1;
                        ocp_reg  <= (hs_reg - AW'(OVERHEAD) < AW'(op_reg.req))
                                    ? 16'(hs_reg - AW'(OVERHEAD)) : op_reg.req;
                        wret_reg <= S_FREE;
                        a_reg    <= h_reg;
                    end
                    else
                    begin
                        if (ph_reg == PH_ALLOC_FIT)
                            ores_reg <= 16'(a_reg + AW'(TAG_SPAN));
                        wret_reg <= S_DONE;
                    end
                    st_reg <= S_WR;
                end
                S_FREE:
                begin
                    // a_reg = h_reg; mark free then merge
                    wa_reg[0] <= h_reg;
                    wd_reg[0] <= {hs_reg, 1'b1};
                    wa_reg[1] <= h_reg + hs_reg - AW'(TAG_SPAN);
                    wd_reg[1] <= {hs_reg, 1'b1};
                    wn_reg <= 3'd2; wi_reg <= '0;
                    a_reg  <= h_reg;
                    sz_reg <= hs_reg;
                    wret_reg <= S_MPRD;
                    st_reg <= S_WR;
                end
                S_MPRD:
                begin
                    p_reg   <= a_reg;
                    tot_reg <= sz_reg;
                    pf_reg  <= 1'b0;
                    nf_reg  <= 1'b0;
                    st_reg  <= (a_reg >= AW'(TAG_SPAN)) ? S_MPCHK : S_MNRD;
                end
                S_MPCHK:
                begin
                    if (rfree && rsz >= AW'(MIN_SPAN) && rsz <= a_reg)
                    begin
                        pf_reg  <= 1'b1;
                        p_reg   <= a_reg - rsz;
                        tot_reg <= tot_reg + rsz;
                    end
                    st_reg <= S_MNRD;
                end
                S_MNRD:
                begin
                    nsz_reg <= a_reg + sz_reg;
                    st_reg  <= S_MNCHK;
                end
                S_MNCHK:
                begin
                    if (nsz_reg < AW'(POOL_USE) && rfree && sane(nsz_reg, rsz))
                    begin
                        nf_reg  <= 1'b1;
                        tot_reg <= tot_reg + rsz;
                    end
                    st_reg <= S_MWR;
                end
                S_MWR:
                begin
                    if (pf_reg || nf_reg)
                    begin
                        wa_reg[0] <= p_reg;
                        wd_reg[0] <= {tot_reg, 1'b1};
                        wa_reg[1] <= p_reg + tot_reg - AW'(TAG_SPAN);
                        wd_reg[1] <= {tot_reg, 1'b1};
                        wn_reg <= 3'd2; wi_reg <= '0;
                        wret_reg <= S_DONE;
                        st_reg <= S_WR;
                    end
                    else
                        st_reg <= S_DONE;
                end
                S_WR:
                begin
                    if (wi_reg + 3'd1 == wn_reg)
                        st_reg <= wret_reg;
                    wi_reg <= wi_reg + 3'd1;
                end
                S_DONE:
                begin
                    ph_reg <= PH_NONE;
                    st_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (rsp_ready)
                        st_reg <= S_IDLE;
                end
                default: st_reg <= S_IDLE;
            endcase
        end
    end
endmodule
